// ===== hdl/speck64_96_block_encrypt_defines.svh =====
// Assertion macros used by the Speck64/96 port checker.
`ifndef SPECK64_96_BLOCK_ENCRYPT_DEFINES_SVH
`define SPECK64_96_BLOCK_ENCRYPT_DEFINES_SVH

// Check at every clock edge outside reset.
`define SPK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check at every clock edge, reset included.
`define SPK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ===== hdl/spk_pkg.sv =====
// Types, constants and the round function of the Speck64/96 encryption block.
package spk_pkg;

  localparam int unsigned ROUNDS    = 26;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RND_IDX_W = $clog2(ROUNDS);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROT_R     = 8;
  localparam int unsigned ROT_L     = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef word_t [ROUNDS-1:0] round_keys_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } word_pair_t;

  // Key register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_ZERO = 2'd0,
    CFG_KEY_WORD_ONE  = 2'd1,
    CFG_KEY_WORD_TWO  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KS_IDLE,
    KS_RUN
  } ks_state_e;

  // One Speck round: a = (ror(a) + b) ^ k, b = rol(b) ^ a.
  function automatic word_pair_t spk_round(word_t a, word_t b, word_t k);
    word_pair_t res;
    word_t      hi;
    hi    = ({a[ROT_R-1:0], a[WORD_W-1:ROT_R]} + b) ^ k;
    res.a = hi;
    res.b = {b[WORD_W-ROT_L-1:0], b[WORD_W-1:WORD_W-ROT_L]} ^ hi;
    return res;
  endfunction

endpackage

// ===== hdl/spk_if.sv =====
// Channel interfaces: key write port, plaintext input and ciphertext output.
interface spk_cfg_if
  import spk_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface spk_plain_if
  import spk_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t plain_x;
  word_t plain_y;

  modport source (output valid, output plain_x, output plain_y, input ready);
  modport sink   (input valid, input plain_x, input plain_y, output ready);
endinterface

interface spk_cipher_if
  import spk_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t cipher_x;
  word_t cipher_y;

  modport source (output valid, output cipher_x, output cipher_y, input ready);
  modport sink   (input valid, input cipher_x, input cipher_y, output ready);
endinterface

// ===== hdl/spk_key_sched.sv =====
// Key registers and iterative round key expansion, one round key per cycle.
module spk_key_sched
  import spk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spk_cfg_if.sink     cfg_i,
  output round_keys_t round_keys_o,
  output logic        busy_o
);

  localparam logic [RND_IDX_W-1:0] LastIdx = RND_IDX_W'(ROUNDS - 1);

  ks_state_e state_q, state_d;

  word_t key0_q, key0_d;
  word_t key1_q, key1_d;
  word_t key2_q, key2_d;
  logic  start;

  logic [RND_IDX_W-1:0] cnt_q, cnt_d;
  word_t                low_q, sa_q, sb_q;
  word_t                rk_q [ROUNDS];
  word_pair_t           step;
  logic                 busy;

  assign cfg_i.ready = 1'b1;

  // Decode key word writes; an unknown index changes nothing.
  always_comb begin
    key0_d = key0_q;
    key1_d = key1_q;
    key2_d = key2_q;
    start  = 1'b0;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_KEY_WORD_ZERO: begin
          key0_d = cfg_i.data;
          start  = 1'b1;
        end
        CFG_KEY_WORD_ONE: begin
          key1_d = cfg_i.data;
          start  = 1'b1;
        end
        CFG_KEY_WORD_TWO: begin
          key2_d = cfg_i.data;
          start  = 1'b1;
        end
        default: start = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      KS_IDLE: if (start) state_d = KS_RUN;
      KS_RUN:  if (!start && cnt_q == LastIdx) state_d = KS_IDLE;
      default: state_d = KS_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      KS_RUN:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Even steps advance the first schedule word, odd steps the second.
  assign step = spk_round(cnt_q[0] ? sb_q : sa_q, low_q, WORD_W'(cnt_q));

  always_comb begin
    cnt_d = cnt_q;
    if (start) begin
      cnt_d = '0;
    end else if (busy) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_IDLE;
      cnt_q   <= '0;
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      key0_q  <= key0_d;
      key1_q  <= key1_d;
      key2_q  <= key2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      low_q <= key0_d;
      sa_q  <= key1_d;
      sb_q  <= key2_d;
    end else if (busy) begin
      rk_q[cnt_q] <= low_q;
      low_q       <= step.b;
      if (cnt_q[0]) begin
        sb_q <= step.a;
      end else begin
        sa_q <= step.a;
      end
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_rk
    assign round_keys_o[r] = rk_q[r];
  end

  assign busy_o = busy;

endmodule

// ===== hdl/speck64_96_block_encrypt.sv =====
// Speck64/96 encryption top level: unrolled 26-stage round pipeline.
//
// Each plaintext block passes through every stage to become its ciphertext, one round per
// pipeline stage, and a new block is taken every cycle while the output side keeps
// up and no key expansion runs. When the output stalls, the pipeline holds; an empty
// first stage still takes one more block. A key word write starts a round key
// expansion (one schedule round per cycle); plaintext ready stays low until it ends.
// Key writes are always taken. Write all three key words before the first block.
module speck64_96_block_encrypt
  import spk_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  spk_cfg_if.sink       cfg_i,
  spk_plain_if.sink     plain_i,
  spk_cipher_if.source  cipher_o
);

  round_keys_t round_keys;
  logic        ks_busy;

  logic  valid_q [ROUNDS];
  word_t x_q     [ROUNDS];
  word_t y_q     [ROUNDS];

  logic advance;
  logic in_xfer;

  spk_key_sched u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .round_keys_o (round_keys),
    .busy_o       (ks_busy)
  );

  // Move the whole pipeline when the last stage is empty or being drained.
  assign advance       = !valid_q[ROUNDS-1] || cipher_o.ready;
  assign plain_i.ready = !ks_busy && (advance || !valid_q[0]);
  assign in_xfer       = plain_i.valid && plain_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= in_xfer;
    end else if (in_xfer) begin
      valid_q[0] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      {x_q[0], y_q[0]} <= spk_round(plain_i.plain_x, plain_i.plain_y, round_keys[0]);
    end
  end

  for (genvar s = 1; s < ROUNDS; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (advance) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance && valid_q[s-1]) begin
        {x_q[s], y_q[s]} <= spk_round(x_q[s-1], y_q[s-1], round_keys[s]);
      end
    end
  end

  assign cipher_o.valid    = valid_q[ROUNDS-1];
  assign cipher_o.cipher_x = x_q[ROUNDS-1];
  assign cipher_o.cipher_y = y_q[ROUNDS-1];

endmodule

// ===== hdl/spk_checker.sv =====
// Port-level assertions for the Speck64/96 block and their binding.
`include "speck64_96_block_encrypt_defines.svh"

module spk_checker
  import spk_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic                 plain_ready_i,
  input logic                 cipher_valid_i,
  input logic                 cipher_ready_i
);

  logic key_write;

  assign key_write = cfg_valid_i && cfg_ready_i &&
                     (cfg_index_i == CFG_KEY_WORD_ZERO ||
                      cfg_index_i == CFG_KEY_WORD_ONE ||
                      cfg_index_i == CFG_KEY_WORD_TWO);

  `SPK_ASSERT_RST(a_cipher_hold, cipher_valid_i && !cipher_ready_i |=> cipher_valid_i, "ciphertext valid dropped before transfer")
  `SPK_ASSERT_RST(a_key_blocks_input, key_write |=> !plain_ready_i, "plaintext taken during key expansion")
  `SPK_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !cipher_valid_i, "ciphertext valid during reset")
  `SPK_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_i, "key write port not ready")

endmodule

bind speck64_96_block_encrypt spk_checker u_spk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready),
  .cfg_index_i    (cfg_i.index),
  .plain_ready_i  (plain_i.ready),
  .cipher_valid_i (cipher_o.valid),
  .cipher_ready_i (cipher_o.ready)
);

// ===== tb/sv/speck_cipher_checker.sv =====
// Checker for the Speck64/96 encryption block: key schedule and cipher predictor, result compare.
module speck_cipher_checker
  import spk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spk_cfg_if          cfg_mon,
  spk_plain_if        plain_mon,
  spk_cipher_if       cipher_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t x;
    word_t y;
  } cipher_pair_t;

  word_t        key_word [3];
  word_t        round_key_table [ROUNDS];
  cipher_pair_t expected_cipher [$];
  cipher_pair_t oldest_cipher;
  int unsigned  mismatch_count = 0;
  int unsigned  pending_count  = 0;
  int unsigned  checked_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;

  function automatic void mix_round(inout word_t a, inout word_t b, input word_t k);
    word_t sum;
    sum = ((a >> ROT_R) | (a << (WORD_W - ROT_R))) + b;
    a   = sum ^ k;
    b   = ((b << ROT_L) | (b >> (WORD_W - ROT_L))) ^ a;
  endfunction

  // Rebuild the whole schedule from the three current key words.
  function automatic void expand_round_keys();
    word_t low;
    word_t sched [2];
    low      = key_word[0];
    sched[0] = key_word[1];
    sched[1] = key_word[2];
    for (int r = 0; r < ROUNDS; r++) begin
      round_key_table[r] = low;
      mix_round(sched[r % 2], low, word_t'(r));
    end
  endfunction

  function automatic cipher_pair_t encrypt_block(word_t x, word_t y);
    cipher_pair_t res;
    res.x = x;
    res.y = y;
    for (int r = 0; r < ROUNDS; r++) begin
      mix_round(res.x, res.y, round_key_table[r]);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (key_word[i]) key_word[i] = '0;
      foreach (round_key_table[i]) round_key_table[i] = '0;
      expected_cipher.delete();
      pending_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_KEY_WORD_ZERO: begin
            key_word[0] = cfg_mon.data;
            expand_round_keys();
          end
          CFG_KEY_WORD_ONE: begin
            key_word[1] = cfg_mon.data;
            expand_round_keys();
          end
          CFG_KEY_WORD_TWO: begin
            key_word[2] = cfg_mon.data;
            expand_round_keys();
          end
          default: ;
        endcase
      end
      if (plain_mon.valid && plain_mon.ready) begin
        expected_cipher.push_back(encrypt_block(plain_mon.plain_x, plain_mon.plain_y));
      end
      if (cipher_mon.valid && cipher_mon.ready) begin
        if (expected_cipher.size() == 0) begin
          $error("ciphertext with no block outstanding: cipher_x=%h cipher_y=%h",
                 cipher_mon.cipher_x, cipher_mon.cipher_y);
          mismatch_count++;
        end else begin
          oldest_cipher = expected_cipher.pop_front();
          checked_count++;
          if (cipher_mon.cipher_x !== oldest_cipher.x) begin
            $error("cipher_x mismatch: expected %h, actual %h",
                   oldest_cipher.x, cipher_mon.cipher_x);
            mismatch_count++;
          end
          if (cipher_mon.cipher_y !== oldest_cipher.y) begin
            $error("cipher_y mismatch: expected %h, actual %h",
                   oldest_cipher.y, cipher_mon.cipher_y);
            mismatch_count++;
          end
        end
      end
      pending_count = expected_cipher.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the Speck64/96 encryption testbench: clock, reset, key loads, plaintext and ready traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;
  localparam int unsigned RANDOM_PHASES    = 10;
  localparam int unsigned BLOCKS_PER_PHASE = 75;
  localparam int unsigned DRAIN_CYCLES     = 2 * ROUNDS + 8;
  localparam int unsigned CYCLE_LIMIT      = 400_000;

  logic clk_i;
  logic rst_ni;

  spk_cfg_if    cfg_bus ();
  spk_plain_if  plain_bus ();
  spk_cipher_if cipher_bus ();

  int unsigned fail_count;
  int unsigned pending_blocks;
  int unsigned checked_blocks;
  int unsigned cycle_count  = 0;
  int unsigned sent_blocks  = 0;
  int unsigned key_writes   = 0;
  int unsigned stray_writes = 0;
  bit          steady_sender = 1'b0;

  speck64_96_block_encrypt u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .plain_i  (plain_bus),
    .cipher_o (cipher_bus)
  );

  speck_cipher_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .plain_mon    (plain_bus),
    .cipher_mon   (cipher_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_blocks),
    .checked_o    (checked_blocks)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_sender || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t rand_word();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom();
  endfunction

  // Leave valid high when another write follows directly.
  task automatic write_key(input logic [CFG_IDX_W-1:0] index, input word_t value,
                           input bit last);
    bit taken;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    key_writes++;
    if (index == CFG_IDX_UNMAPPED) stray_writes++;
    if (last) cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_key(input word_t k0, input word_t k1, input word_t k2);
    write_key(CFG_KEY_WORD_ZERO, k0, 1'b0);
    write_key(CFG_KEY_WORD_ONE, k1, 1'b0);
    write_key(CFG_KEY_WORD_TWO, k2, 1'b1);
  endtask

  task automatic send_block(input word_t x, input word_t y);
    bit          taken;
    int unsigned gap;
    plain_bus.valid   <= 1'b1;
    plain_bus.plain_x <= x;
    plain_bus.plain_y <= y;
    do begin
      @(negedge clk_i);
      taken = plain_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    sent_blocks++;
    gap = pick_gap();
    if (gap > 0) begin
      plain_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every ciphertext has come back.
  task automatic drain_pipeline();
    plain_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending_blocks != 0);
    @(posedge clk_i);
  endtask

  task automatic load_random_key();
    case ($urandom_range(0, 3))
      0, 1: load_key(rand_word(), rand_word(), rand_word());
      2: write_key(cfg_idx_e'($urandom_range(0, 2)), rand_word(), 1'b1);
      default: load_key($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0,
                        $urandom_range(0, 1) ? '1 : '0);
    endcase
    if ($urandom_range(0, 3) == 0) write_key(CFG_IDX_UNMAPPED, rand_word(), 1'b1);
  endtask

  // Hold ready in runs, with occasional long stalls and long stall-free stretches.
  initial begin
    cipher_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        cipher_bus.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        cipher_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        cipher_bus.ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk_i);
        else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= '0;
    cfg_bus.data      <= '0;
    plain_bus.valid   <= 1'b0;
    plain_bus.plain_x <= '0;
    plain_bus.plain_y <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Published key and plaintext, then field extremes and alternating patterns.
    load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110);
    send_block(32'h7461_4620, 32'h736e_6165);
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'h5555_5555, 32'haaaa_aaaa);
    send_block(32'haaaa_aaaa, 32'h5555_5555);
    drain_pipeline();

    load_key('0, '0, '0);
    send_block('0, '0);
    send_block(32'h7461_4620, 32'h736e_6165);
    drain_pipeline();

    load_key('1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain_pipeline();

    // Partial key update: one word rewritten, the others kept.
    write_key(CFG_KEY_WORD_TWO, 32'h1234_5678, 1'b1);
    send_block(32'hdead_beef, 32'h0bad_f00d);
    send_block('1, '0);
    drain_pipeline();

    // Write to an unmapped index must leave the schedule alone.
    write_key(CFG_IDX_UNMAPPED, 32'hffff_0000, 1'b1);
    send_block(32'hdead_beef, 32'h0bad_f00d);
    send_block(32'h0f0f_0f0f, 32'hf0f0_f0f0);
    drain_pipeline();

    write_key(CFG_KEY_WORD_ZERO, 32'h8000_0001, 1'b1);
    send_block(32'hdead_beef, 32'h0bad_f00d);
    drain_pipeline();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      load_random_key();
      for (int i = 0; i < BLOCKS_PER_PHASE; i++) send_block(rand_word(), rand_word());
      drain_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Encrypted %0d blocks, %0d ciphertexts checked in order", sent_blocks,
             checked_blocks);
    $display("Key port saw %0d writes, %0d of them to the unmapped index", key_writes,
             stray_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
